// File: rtl/rclfr_pkg.sv
// rclfr_pkg: shared constants, codes and control/status structs of the RC link
// frame receiver. Used by rclfr_ctrl, rclfr_datapath and rc_link_frame_receiver.
package rclfr_pkg;

    // frame geometry
    localparam int MAX_FRAME    = 64;
    localparam int NUM_CHANNELS = 16;
    localparam int AW           = $clog2(MAX_FRAME);      // frame store address
    localparam int POS_W        = $clog2(MAX_FRAME + 1);  // byte position, holds MAX_FRAME
    localparam int LEN_CMP_W    = 9;                      // length + 2 without overflow

    // channel unpacking
    localparam int RAW_W  = 11;
    localparam int ACC_W  = RAW_W - 1 + 8;  // at most 10 leftover bits plus one byte
    localparam int HAVE_W = 5;
    localparam int IDX_W  = 4;
    localparam int US_W   = 12;

    localparam logic [AW-1:0] FIRST_PAYLOAD = AW'(3);

    // address bytes and frame type
    localparam logic [7:0] ADDR_FC    = 8'hC8;
    localparam logic [7:0] ADDR_RX    = 8'hEE;
    localparam logic [7:0] ADDR_TX    = 8'hEA;
    localparam logic [7:0] TYPE_CHANS = 8'h16;
    localparam logic [7:0] CRC_POLY   = 8'hD5;

    // 172..1811 -> 988..2012: q = d*1024/1639, done as a multiply by a rounded-up
    // reciprocal of 2^32/1639 and a shift (exact for 11-bit d)
    localparam logic [RAW_W-1:0] RAW_MIN     = RAW_W'(172);
    localparam logic [US_W-1:0]  US_MID      = US_W'(988);
    localparam int               RECIP_W     = 22;
    localparam int               RECIP_SHIFT = 22;
    localparam logic [RECIP_W-1:0] US_RECIP  =
        RECIP_W'(((64'd1 << 32) + 64'd1638) / 64'd1639);

    // configuration
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_LINK_TIMEOUT = '0;
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;

    typedef enum logic [2:0] {
        EV_BYTE        = 3'd0,
        EV_CHANNEL     = 3'd1,
        EV_CRC_ERR     = 3'd2,
        EV_OTHER_FRAME = 3'd3,
        EV_LINK_LOST   = 3'd4,
        EV_BAD_LENGTH  = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic accept;    // input item taken this cycle
        logic rd_start;  // begin unpacking: read first payload byte
        logic ld;        // merge read byte into accumulator, read next
        logic emit;      // write one channel result
    } t_cmd;

    typedef struct packed {
        logic out_free;      // output register can take a result
        logic start_unpack;  // current input closes a good channel frame
        logic ld_full;       // after the merge, a whole channel is present
        logic last_ch;       // channel being emitted is the last one
    } t_stat;

endpackage

// File: rtl/rclfr_ctrl.sv
// rclfr_ctrl: sequencer of the frame receiver; input handshake and channel
// unpack steps. Depends on rclfr_pkg.
module rclfr_ctrl
    import rclfr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall   = !i_stat.out_free;
                o_cmd.accept = i_in_valid && i_stat.out_free;
                if (o_cmd.accept && i_stat.start_unpack) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_start = 1'b1;
                n_state        = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.ld = 1'b1;
                if (i_stat.ld_full) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // at most 7 bits stay after a channel, so another byte is always due
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.last_ch ? S_IDLE : S_LOAD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: rtl/rclfr_datapath.sv
// rclfr_datapath: frame store, frame parsing, running CRC, link timer, channel
// unpacker and output register. Depends on rclfr_pkg.
module rclfr_datapath
    import rclfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [15:0]       i_timeout,
    input  logic              i_operation,
    input  logic [7:0]        i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_event_res,
    output logic [IDX_W-1:0]  o_channel_index,
    output logic [RAW_W-1:0]  o_channel_raw,
    output logic [US_W-1:0]   o_channel_us,
    output logic              o_link_up,
    output logic [7:0]        o_frame_type,
    output logic              o_last
);

    function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] x;
        x = c ^ b;
        for (int k = 0; k < 8; k++) begin
            x = x[7] ? ((x << 1) ^ CRC_POLY) : (x << 1);
        end
        return x;
    endfunction

    // frame store with per-entry valid bits (unwritten entries read as zero)
    logic [7:0]           mem [MAX_FRAME];
    logic [MAX_FRAME-1:0] r_vld;
    logic [7:0]           r_rd_data;
    logic                 r_rd_vld;
    logic                 we, re;
    logic [AW-1:0]        waddr, raddr;

    // parser state
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [7:0]        r_len, n_len;
    logic [7:0]        r_crc, n_crc;
    logic [7:0]        r_type, n_type;
    logic              r_link, n_link;
    logic [15:0]       r_ticks, n_ticks;

    // unpacker
    logic [AW-1:0]     r_rd_addr, n_rd_addr;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [HAVE_W-1:0] r_have, n_have;
    logic [IDX_W-1:0]  r_ch, n_ch;

    // output register
    logic              r_ov;
    t_event            r_ev;
    logic [IDX_W-1:0]  r_idx;
    logic [RAW_W-1:0]  r_raw;
    logic [US_W-1:0]   r_us;
    logic              r_lk;
    logic [7:0]        r_ty;
    logic              r_last;

    logic                 out_free;
    logic [POS_W-1:0]     pos_inc;
    logic                 frame_end, crc_ok, is_chan, is_addr, bad_len, lost;
    logic [15:0]          ticks_inc;
    t_event               acc_ev;
    logic [7:0]           acc_type;
    logic [7:0]           rd_byte;
    logic [RAW_W-1:0]     raw, mag;
    logic                 neg;
    logic [RAW_W+RECIP_W-1:0] prod;
    logic [RAW_W-1:0]     quo;
    logic [US_W-1:0]      us;

    assign out_free  = !r_ov || !i_out_stall;
    assign pos_inc   = r_pos + POS_W'(1);
    assign frame_end = LEN_CMP_W'(pos_inc) == (LEN_CMP_W'(r_len) + LEN_CMP_W'(2));
    assign crc_ok    = i_rx_byte == r_crc;
    assign is_chan   = r_type == TYPE_CHANS;
    assign is_addr   = (i_rx_byte == ADDR_FC) || (i_rx_byte == ADDR_RX) ||
                       (i_rx_byte == ADDR_TX);
    assign bad_len   = (i_rx_byte < 8'd2) ||
                       (LEN_CMP_W'(i_rx_byte) > LEN_CMP_W'(MAX_FRAME - 2));
    assign ticks_inc = (r_ticks == 16'hFFFF) ? r_ticks : r_ticks + 16'd1;
    assign lost      = r_link && (ticks_inc > i_timeout);

    always_comb begin
        o_stat.out_free     = out_free;
        o_stat.start_unpack = !i_operation && (r_pos >= POS_W'(2)) && frame_end &&
                              crc_ok && is_chan;
        o_stat.ld_full      = r_have >= HAVE_W'(3);
        o_stat.last_ch      = r_ch == IDX_W'(NUM_CHANNELS - 1);
    end

    // item handling
    always_comb begin
        n_pos    = r_pos;
        n_len    = r_len;
        n_crc    = r_crc;
        n_type   = r_type;
        n_link   = r_link;
        n_ticks  = r_ticks;
        we       = 1'b0;
        waddr    = r_pos[AW-1:0];
        acc_ev   = EV_BYTE;
        acc_type = 8'd0;
        if (i_cmd.accept) begin
            if (i_operation) begin
                n_ticks = ticks_inc;
                if (lost) begin
                    n_link = 1'b0;
                    acc_ev = EV_LINK_LOST;
                end
            end else if (r_pos == POS_W'(0)) begin
                if (is_addr) begin
                    we    = 1'b1;
                    n_pos = POS_W'(1);
                end
            end else if (r_pos == POS_W'(1)) begin
                n_len = i_rx_byte;
                if (bad_len) begin
                    n_pos  = POS_W'(0);
                    acc_ev = EV_BAD_LENGTH;
                end else begin
                    we    = 1'b1;
                    n_pos = POS_W'(2);
                end
            end else begin
                we = 1'b1;
                if (r_pos == POS_W'(2)) begin
                    n_type = i_rx_byte;
                    n_crc  = crc8_step(8'd0, i_rx_byte);
                end else if (LEN_CMP_W'(r_pos) <= LEN_CMP_W'(r_len)) begin
                    n_crc = crc8_step(r_crc, i_rx_byte);
                end
                if (frame_end) begin
                    n_pos    = POS_W'(0);
                    acc_type = r_type;
                    if (!crc_ok) begin
                        acc_ev = EV_CRC_ERR;
                    end else if (!is_chan) begin
                        acc_ev = EV_OTHER_FRAME;
                    end else begin
                        n_link  = 1'b1;
                        n_ticks = 16'd0;
                    end
                end else begin
                    n_pos = (pos_inc >= POS_W'(MAX_FRAME)) ? POS_W'(0) : pos_inc;
                end
            end
        end
    end

    // unpacker and microsecond map
    assign re      = i_cmd.rd_start || i_cmd.ld;
    assign raddr   = i_cmd.rd_start ? FIRST_PAYLOAD : r_rd_addr;
    assign rd_byte = r_rd_vld ? r_rd_data : 8'd0;
    assign raw     = r_acc[RAW_W-1:0];
    assign neg     = raw < RAW_MIN;
    assign mag     = neg ? (RAW_MIN - raw) : (raw - RAW_MIN);
    assign prod    = (RAW_W+RECIP_W)'(mag) * (RAW_W+RECIP_W)'(US_RECIP);
    assign quo     = prod[RECIP_SHIFT +: RAW_W];
    assign us      = neg ? (US_MID - US_W'(quo)) : (US_MID + US_W'(quo));

    always_comb begin
        n_rd_addr = r_rd_addr;
        n_acc     = r_acc;
        n_have    = r_have;
        n_ch      = r_ch;
        if (i_cmd.rd_start) begin
            n_rd_addr = FIRST_PAYLOAD + AW'(1);
            n_acc     = '0;
            n_have    = '0;
            n_ch      = '0;
        end else if (i_cmd.ld) begin
            n_rd_addr = r_rd_addr + AW'(1);
            n_acc     = r_acc | (ACC_W'(rd_byte) << r_have);
            n_have    = r_have + HAVE_W'(8);
        end else if (i_cmd.emit) begin
            n_acc  = r_acc >> RAW_W;
            n_have = r_have - HAVE_W'(RAW_W);
            n_ch   = r_ch + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= i_rx_byte;
        end
        if (re) begin
            r_rd_data <= mem[raddr];
            r_rd_vld  <= r_vld[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_pos   <= '0;
            r_len   <= '0;
            r_crc   <= '0;
            r_type  <= '0;
            r_link  <= 1'b0;
            r_ticks <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (we) begin
                r_vld[waddr] <= 1'b1;
            end
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_crc   <= n_crc;
            r_type  <= n_type;
            r_link  <= n_link;
            r_ticks <= n_ticks;
            if ((i_cmd.accept && !o_stat.start_unpack) || i_cmd.emit) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        r_acc     <= n_acc;
        r_have    <= n_have;
        r_ch      <= n_ch;
        if (i_cmd.accept && !o_stat.start_unpack) begin
            r_ev   <= acc_ev;
            r_idx  <= '0;
            r_raw  <= '0;
            r_us   <= '0;
            r_lk   <= n_link;
            r_ty   <= acc_type;
            r_last <= 1'b1;
        end else if (i_cmd.emit) begin
            r_ev   <= EV_CHANNEL;
            r_idx  <= r_ch;
            r_raw  <= raw;
            r_us   <= us;
            r_lk   <= r_link;
            r_ty   <= r_type;
            r_last <= o_stat.last_ch;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_event_res     = r_ev;
    assign o_channel_index = r_idx;
    assign o_channel_raw   = r_raw;
    assign o_channel_us    = r_us;
    assign o_link_up       = r_lk;
    assign o_frame_type    = r_ty;
    assign o_last          = r_last;

endmodule

// File: rtl/rc_link_frame_receiver.sv
// rc_link_frame_receiver: top level of the RC link frame receiver; config
// register, sequencer and datapath. Depends on rclfr_pkg, rclfr_ctrl, rclfr_datapath.
//
// Takes one item per handshake: a received serial byte (operation 0) or a
// millisecond tick (operation 1). Bytes are framed as address (0xC8/0xEE/0xEA),
// length (2..MAX_FRAME-2, else resync with a bad-length event), type, payload
// and a CRC-8 (poly 0xD5) over type and payload. Every item gives one result,
// except a good channel frame (type 0x16) whose closing byte gives sixteen
// channel results: 11-bit raw value unpacked LSB-first from payload bytes 3..24
// and its microsecond value. Such a frame raises link_up and clears the tick
// count; ticks count up (saturating at 65535) and drop the link with a link-lost
// event once the count exceeds link_timeout_ms (APB register at address 0,
// reset 500). Rate: a byte or tick is taken while the output register is free
// or being emptied, so one item per cycle while there is no back pressure and
// no frame is unpacked. The closing byte of a channel frame starts a busy phase,
// input stalled (one read setup, 22 payload byte reads, 16 result writes), set
// by the single read port of the frame store and the one-deep output register;
// output stalls lengthen it. The frame store reads as zero until written (valid
// bit per entry cleared by reset), so there is no clearing pass.
module rc_link_frame_receiver
    import rclfr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic [7:0]         i_rx_byte,
    // result items
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_event_res,
    output logic [IDX_W-1:0]   o_channel_index,
    output logic [RAW_W-1:0]   o_channel_raw,
    output logic [US_W-1:0]    o_channel_us,
    output logic               o_link_up,
    output logic [7:0]         o_frame_type,
    output logic               o_last
);

    logic [15:0] r_link_timeout_ms;
    logic        cfg_wr;
    logic        sel_timeout;
    t_cmd        cmd;
    t_stat       stat;

    // register index is the word address; bits below it are byte lanes
    assign sel_timeout = paddr[PADDR_W-1:2] == REG_LINK_TIMEOUT;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign prdata      = sel_timeout ? {16'd0, r_link_timeout_ms} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_timeout_ms <= TIMEOUT_RESET;
        end else if (cfg_wr && sel_timeout) begin
            r_link_timeout_ms <= pwdata[15:0];
        end
    end

    rclfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rclfr_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_timeout       (r_link_timeout_ms),
        .i_operation     (i_operation),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_event_res     (o_event_res),
        .o_channel_index (o_channel_index),
        .o_channel_raw   (o_channel_raw),
        .o_channel_us    (o_channel_us),
        .o_link_up       (o_link_up),
        .o_frame_type    (o_frame_type),
        .o_last          (o_last)
    );

endmodule
